@@ hdl/max_falling_path_sum_unit_assert.svh @@
// Assertion macros used by the falling path sum datapath (mfps_dp).
// Include by bare file name inside a module body; no other dependencies.
`ifndef MAX_FALLING_PATH_SUM_UNIT_ASSERT_SVH
`define MAX_FALLING_PATH_SUM_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MFPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mfps_pkg.sv @@
// Shared types and constants of the falling path sum unit.
// No dependencies; imported by the sequencer, datapath and top level.
`default_nettype none

package mfps_pkg;

  localparam int CellW    = 16;
  localparam int SumW     = 32;
  localparam int NumColsW = 7;

  localparam logic [NumColsW-1:0] NumColsRst = NumColsW'(64);

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // Per-cell control handed from the sequencer to the datapath.
  typedef struct packed {
    logic first_row;
    logic left_ok;
    logic right_ok;
    logic row_end;
    logic last;
  } mfps_ctl_t;

endpackage

`default_nettype wire

@@ hdl/mfps_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mfps_ram #(
  parameter  int Width = 32,
  parameter  int Depth = 128,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/mfps_seq.sv @@
// Column sequencer: width register, column/row/half tracking, row store addresses.
// Depends on mfps_pkg.
`default_nettype none

module mfps_seq
  import mfps_pkg::*;
#(
  parameter  int MaxCols = 64,
  localparam int AddrW   = $clog2(2 * MaxCols)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [NumColsW-1:0]   cfg_data_i,
  input  wire logic                  accept_i,
  input  wire logic                  last_i,
  output      mfps_ctl_t             ctl_o,
  output      logic                  re_o,
  output      logic [AddrW-1:0]      raddr_o,
  output      logic [AddrW-1:0]      waddr_o
);

  localparam int ColW  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int NumW  = (ColW + 1 > NumColsW) ? ColW + 1 : NumColsW;

  logic [NumColsW-1:0] num_cols_q;
  logic [ColW-1:0]     col_q;
  logic                first_row_q;
  logic                half_q;

  logic [NumW-1:0]     num_ext;
  logic [NumW-1:0]     eff_cols;
  logic [NumW-1:0]     col_nx;
  logic                right_ok;

  assign cfg_ready_o = 1'b1;

  // Clamp the width register to 1..MaxCols.
  always_comb begin
    num_ext = NumW'(num_cols_q);
    priority if (num_ext == '0) begin
      eff_cols = NumW'(1);
    end else if (num_ext > NumW'(MaxCols)) begin
      eff_cols = NumW'(MaxCols);
    end else begin
      eff_cols = num_ext;
    end
  end

  assign col_nx   = NumW'(col_q) + NumW'(1);
  assign right_ok = (col_nx < eff_cols);

  assign ctl_o.first_row = first_row_q;
  assign ctl_o.left_ok   = (col_q != '0);
  assign ctl_o.right_ok  = right_ok;
  assign ctl_o.row_end   = !right_ok;
  assign ctl_o.last      = last_i;

  // Fetch the right neighbor from the previous-row half; write into the other half.
  assign re_o    = accept_i && right_ok;
  assign raddr_o = half_q ? AddrW'(MaxCols) + AddrW'(col_nx) : AddrW'(col_nx);
  assign waddr_o = half_q ? AddrW'(col_q) : AddrW'(MaxCols) + AddrW'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q  <= NumColsRst;
      col_q       <= '0;
      first_row_q <= 1'b1;
      half_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        num_cols_q <= cfg_data_i;
      end
      if (accept_i) begin
        priority if (last_i) begin
          col_q       <= '0;
          first_row_q <= 1'b1;
          half_q      <= 1'b0;
        end else if (!right_ok) begin
          col_q       <= '0;
          first_row_q <= 1'b0;
          half_q      <= !half_q;
        end else begin
          col_q <= col_nx[ColW-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/mfps_dp.sv @@
// Compute stage: neighbor window, forwarding, saturating add, row best, result register.
// Depends on mfps_pkg and the assertion macro header.
`default_nettype none

module mfps_dp
  import mfps_pkg::*;
#(
  parameter int AddrW = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  output      logic                    in_ready_o,
  input  wire logic signed [CellW-1:0] cell_i,
  input  wire mfps_ctl_t               ctl_i,
  input  wire logic                    re_i,
  input  wire logic [AddrW-1:0]        raddr_i,
  input  wire logic [AddrW-1:0]        waddr_i,
  input  wire logic [SumW-1:0]         rdata_i,
  output      logic                    we_o,
  output      logic [AddrW-1:0]        waddr_o,
  output      logic [SumW-1:0]         wdata_o,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic [SumW-1:0]         best_sum_o,
  output      logic                    saturated_o
);

  logic                    s1_valid_q;
  mfps_ctl_t               ctl_q;
  logic signed [CellW-1:0] cell_q;
  logic [AddrW-1:0]        waddr_q;
  logic                    fwd_q;
  logic signed [SumW-1:0]  fwd_data_q;
  logic signed [SumW-1:0]  win_left_q;
  logic signed [SumW-1:0]  win_cur_q;
  logic signed [SumW-1:0]  first_sum_q;
  logic signed [SumW-1:0]  row_best_q;
  logic                    clamp_q;
  logic                    out_valid_q;
  logic [SumW-1:0]         out_sum_q;
  logic                    out_sat_q;

  logic                    s1_move;
  logic signed [SumW-1:0]  right_val;
  logic signed [SumW-1:0]  best_lc;
  logic signed [SumW-1:0]  best_up;
  logic signed [SumW:0]    sum_w;
  logic                    ovf;
  logic signed [SumW-1:0]  sum32;
  logic signed [SumW-1:0]  row_best_d;
  logic                    clamp_d;

  // A waiting result blocks only a last cell from leaving the stage.
  assign s1_move    = s1_valid_q && !(ctl_q.last && out_valid_q && !out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;

  assign right_val = fwd_q ? fwd_data_q : $signed(rdata_i);

  always_comb begin
    best_lc = win_cur_q;
    if (ctl_q.left_ok && (win_left_q > win_cur_q)) begin
      best_lc = win_left_q;
    end
    best_up = best_lc;
    if (ctl_q.right_ok && (right_val > best_lc)) begin
      best_up = right_val;
    end
  end

  always_comb begin
    if (ctl_q.first_row) begin
      sum_w = (SumW+1)'(cell_q);
    end else begin
      sum_w = (SumW+1)'(best_up) + (SumW+1)'(cell_q);
    end
    ovf = (sum_w[SumW] != sum_w[SumW-1]);
    if (ovf) begin
      sum32 = sum_w[SumW] ? SumMin : SumMax;
    end else begin
      sum32 = sum_w[SumW-1:0];
    end
    row_best_d = (!ctl_q.left_ok || (sum32 > row_best_q)) ? sum32 : row_best_q;
    clamp_d    = clamp_q || ovf;
  end

  assign we_o    = s1_move;
  assign waddr_o = waddr_q;
  assign wdata_o = sum32;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      row_best_q  <= '0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= re_i && s1_move && (waddr_q == raddr_i);
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        if (ctl_q.last) begin
          row_best_q <= '0;
          clamp_q    <= 1'b0;
        end else begin
          row_best_q <= row_best_d;
          clamp_q    <= clamp_d;
        end
      end
      if (s1_move && ctl_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ctl_q      <= ctl_i;
      cell_q     <= cell_i;
      waddr_q    <= waddr_i;
      fwd_data_q <= sum32;
    end
    if (s1_move) begin
      if (!ctl_q.left_ok) begin
        first_sum_q <= sum32;
      end
      // At row end the previous-row window restarts at column zero of this row.
      if (ctl_q.row_end) begin
        win_cur_q <= ctl_q.left_ok ? first_sum_q : sum32;
      end else begin
        win_left_q <= win_cur_q;
        win_cur_q  <= right_val;
      end
      if (ctl_q.last) begin
        out_sum_q <= row_best_d;
        out_sat_q <= clamp_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_sum_o  = out_sum_q;
  assign saturated_o = out_sat_q;

`include "max_falling_path_sum_unit_assert.svh"

  `MFPS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, s1_valid_q && !s1_move, s1_valid_q && $stable(cell_q), "stalled cell left the compute stage")
  `MFPS_ASSERT_SAME(a_fwd_needs_read, clk_i, rst_ni, s1_valid_q && fwd_q, ctl_q.right_ok, "forward hit on a cell with no right neighbor")
  `MFPS_ASSERT_NEXT(a_grid_restart, clk_i, rst_ni, s1_move && ctl_q.last, !clamp_q && out_valid_q, "grid end did not clear clamp flag or post result")

endmodule

`default_nettype wire

@@ hdl/max_falling_path_sum_unit.sv @@
// Maximum falling path sum over a row-major grid stream.
// Channels: s_axis carries one signed cell per transfer, s_axis_tlast marks the
// final cell of a grid. m_axis carries one result per grid: the best path sum
// of the final row in tdata and a saturation flag in tuser. cfg_* writes the
// row width (cells per row, 0 acts as 1, above MAX_COLS acts as MAX_COLS).
// Throughput: one cell per clock unless a last cell waits on a pending result;
// each cell needs at most one row store read (right neighbor from the previous
// row) and one write, on separate RAM ports. m_axis_tvalid is set as the last
// cell leaves the compute stage. Reset: width returns to 64, a new grid starts
// on the next cell and the row store is not cleared (first-row reads unused).
// Stall: a pending result sits in the output register; cells keep flowing,
// and only the last cell of the following grid waits for m_axis_tready.
// Write the width register only while no result is pending.
// Depends on mfps_pkg, mfps_seq, mfps_dp and mfps_ram.
`default_nettype none

module max_falling_path_sum_unit
  import mfps_pkg::*;
#(
  parameter int MAX_COLS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [NumColsW-1:0] cfg_data_i,     // [6:0] num_cols
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [CellW-1:0]    s_axis_tdata,   // [15:0] cell_value
  input  wire logic                s_axis_tlast,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [SumW-1:0]     m_axis_tdata,   // [31:0] best_sum
  output      logic [0:0]          m_axis_tuser    // [0] saturated
);

  localparam int AddrW = $clog2(2 * MAX_COLS);

  mfps_ctl_t        ctl;
  logic             accept;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr_seq;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [SumW-1:0]  wdata;
  logic [SumW-1:0]  rdata;
  logic             sat;

  assign accept = s_axis_tvalid && s_axis_tready;

  mfps_seq #(
    .MaxCols (MAX_COLS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .last_i      (s_axis_tlast),
    .ctl_o       (ctl),
    .re_o        (re),
    .raddr_o     (raddr),
    .waddr_o     (waddr_seq)
  );

  mfps_ram #(
    .Width (SumW),
    .Depth (2 * MAX_COLS)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mfps_dp #(
    .AddrW (AddrW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_ready_o  (s_axis_tready),
    .cell_i      ($signed(s_axis_tdata)),
    .ctl_i       (ctl),
    .re_i        (re),
    .raddr_i     (raddr),
    .waddr_i     (waddr_seq),
    .rdata_i     (rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .best_sum_o  (m_axis_tdata),
    .saturated_o (sat)
  );

  assign m_axis_tuser = sat;

endmodule

`default_nettype wire

@@ tb/max_falling_path_sum_unit_monitor.sv @@
// Watches the width, cell and result channels of the falling path sum unit.
// Predicts each grid's best path sum and saturation flag, and compares results.
// Depends on mfps_pkg.
module max_falling_path_sum_unit_monitor
  import mfps_pkg::*;
#(
  parameter int MAX_COLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [NumColsW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [CellW-1:0]    s_axis_tdata,    // [15:0] cell_value
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [SumW-1:0]     m_axis_tdata,    // [31:0] best_sum
  input  logic [0:0]          m_axis_tuser,    // [0] saturated
  output int                  fault_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SumW-1:0] best_sum;
    logic            saturated;
  } grid_result_t;

  grid_result_t results_due[$];

  // Best path sums of the two most recent rows, one half each.
  logic signed [SumW-1:0] path_sums [0:2*MAX_COLS-1];
  logic [NumColsW-1:0]    width_q;
  int unsigned            col_q;
  logic                   first_row_q;
  logic signed [SumW-1:0] row_best_q;
  logic                   half_q;
  logic                   clamp_q;

  function automatic void restart_grid();
    col_q       = 0;
    first_row_q = 1'b1;
    row_best_q  = '0;
    half_q      = 1'b0;
    clamp_q     = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grid_result_t           due;
    logic signed [CellW-1:0] value;
    logic signed [SumW-1:0]  clipped;
    longint                  path_sum;
    int unsigned             span;
    int unsigned             base;
    if (!rst_ni) begin
      width_q = NumColsRst;
      restart_grid();
      results_due.delete();
      fault_count_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          if (fault_count_o < 10)
            $display("unexpected result: best_sum %0d saturated %0b",
                     $signed(m_axis_tdata), m_axis_tuser[0]);
          fault_count_o++;
        end else begin
          due = results_due.pop_front();
          if (m_axis_tdata !== due.best_sum || m_axis_tuser[0] !== due.saturated) begin
            if (fault_count_o < 10)
              $display("mismatch: best_sum exp %0d got %0d, saturated exp %0b got %0b",
                       $signed(due.best_sum), $signed(m_axis_tdata), due.saturated,
                       m_axis_tuser[0]);
            fault_count_o++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i)
        width_q = cfg_data_i;

      if (s_axis_tvalid && s_axis_tready) begin
        span = (width_q == 0) ? 1 : (width_q > MAX_COLS) ? MAX_COLS : width_q;
        value = s_axis_tdata;
        base = half_q ? MAX_COLS : 0;
        if (first_row_q) begin
          path_sum = value;
        end else begin
          // take the best of above, above-left and above-right within the row
          path_sum = path_sums[base + col_q];
          if (col_q > 0 && path_sums[base + col_q - 1] > path_sum)
            path_sum = path_sums[base + col_q - 1];
          if (col_q + 1 < span && path_sums[base + col_q + 1] > path_sum)
            path_sum = path_sums[base + col_q + 1];
          path_sum += value;
        end
        if (path_sum > longint'(SumMax)) begin
          path_sum = SumMax;
          clamp_q = 1'b1;
        end else if (path_sum < longint'(SumMin)) begin
          path_sum = SumMin;
          clamp_q = 1'b1;
        end
        clipped = path_sum[SumW-1:0];
        path_sums[(half_q ? 0 : MAX_COLS) + col_q] = clipped;
        if (col_q == 0 || clipped > row_best_q)
          row_best_q = clipped;

        if (s_axis_tlast) begin
          due.best_sum = row_best_q;
          due.saturated = clamp_q;
          results_due.push_back(due);
          restart_grid();
        end else if (col_q + 1 >= span) begin
          // row done: swap halves
          col_q = 0;
          first_row_q = 1'b0;
          half_q = !half_q;
        end else begin
          col_q++;
        end
      end
      pending_o = results_due.size();
    end
  end

endmodule

@@ tb/max_falling_path_sum_unit_tb.sv @@
// Top of the falling path sum testbench: clock, reset, cell and width stimulus,
// result back-pressure, watchdog and verdict. Depends on mfps_pkg,
// max_falling_path_sum_unit and max_falling_path_sum_unit_monitor.
module max_falling_path_sum_unit_tb
  import mfps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCols = 64;
  localparam int StallLimit = 1000;
  localparam logic signed [CellW-1:0] CellMax = 16'sh7FFF;
  localparam logic signed [CellW-1:0] CellMin = 16'sh8000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [NumColsW-1:0] cfg_data_i;     // [6:0] num_cols
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [CellW-1:0]    s_axis_tdata;   // [15:0] cell_value
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SumW-1:0]     m_axis_tdata;   // [31:0] best_sum
  logic [0:0]          m_axis_tuser;   // [0] saturated

  int                  fault_count;
  int                  pending;
  logic                quiet = 1'b0;
  logic [NumColsW-1:0] width_now = NumColsRst;
  int unsigned         idle_cycles = 0;

  max_falling_path_sum_unit #(
    .MAX_COLS(MaxCols)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  max_falling_path_sum_unit_monitor #(
    .MAX_COLS(MaxCols)
  ) path_sum_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fault_count_o(fault_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("FAIL max_falling_path_sum_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold ready low for a drawn number of cycles once a result is waiting.
  initial begin : result_sink
    int unsigned hold;
    m_axis_tready = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= (hold == 0);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        hold = quiet ? 0 : $urandom_range(0, 4);
      else if (m_axis_tvalid && hold > 0)
        hold--;
    end
  end

  function automatic logic signed [CellW-1:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return CellMax;
      1:       return CellMin;
      default: return CellW'($urandom);
    endcase
  endfunction

  function automatic logic [NumColsW-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return NumColsW'(MaxCols);
      2:       return NumColsW'($urandom_range(MaxCols + 1, 127));
      3:       return NumColsW'($urandom_range(9, MaxCols - 1));
      default: return NumColsW'($urandom_range(1, 8));
    endcase
  endfunction

  // Called and returns at a falling edge; valid stays high for a back-to-back cell.
  task automatic send_cell(input logic signed [CellW-1:0] value, input logic last);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= CellW'($urandom);
      s_axis_tlast <= 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_width(input logic [NumColsW-1:0] cols);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // let the last cell drain out of the pipeline
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cols;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    width_now = cols;
  endtask

  initial begin : stimulus
    int unsigned k;
    int unsigned n;
    int unsigned rows;
    int unsigned span;
    int unsigned sent;
    int unsigned grids;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill both halves of the row store at the reset width; end in a partial row.
    for (k = 1; k <= 2 * MaxCols + 5; k++)
      send_cell(draw_value(), k == 2 * MaxCols + 5);

    // zero width acts as one column
    write_width('0);
    send_cell(CellMax, 1'b0);
    send_cell(CellMin, 1'b0);
    send_cell(16'sd0, 1'b1);

    // width above MaxCols acts as MaxCols; single-cell grid
    write_width(7'd127);
    send_cell(CellMin, 1'b1);

    write_width(7'd3);
    send_cell(CellMin, 1'b0);
    send_cell(CellMax, 1'b0);
    send_cell(-16'sd1, 1'b0);
    send_cell(16'sd1, 1'b0);
    send_cell(CellMin, 1'b0);
    send_cell(CellMax, 1'b0);
    send_cell(16'sd0, 1'b1);

    // shrink, then grow, the width inside a grid
    write_width(7'd6);
    for (k = 0; k < 8; k++)
      send_cell(CellW'(k * 1000 - 3000), 1'b0);
    write_width(7'd2);
    send_cell(16'sd77, 1'b0);
    send_cell(-16'sd500, 1'b0);
    send_cell(16'sd12345, 1'b0);
    write_width(7'd5);
    send_cell(16'sd3, 1'b0);
    send_cell(CellMax, 1'b0);
    send_cell(CellMin, 1'b0);
    send_cell(-16'sd9, 1'b1);

    sent = 0;
    grids = 0;
    while (sent < 1240 || grids < 40) begin
      if ($urandom_range(0, 2) == 0)
        write_width(pick_width());
      quiet = ($urandom_range(0, 3) == 0);
      span = (width_now == 0) ? 1 : (width_now > MaxCols) ? MaxCols : width_now;
      rows = (span > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      n = (rows - 1) * span + $urandom_range(1, span);
      for (k = 1; k <= n; k++) begin
        if (k > 1 && $urandom_range(0, 40) == 0)
          write_width(pick_width());
        send_cell(draw_value(), k == n);
      end
      sent += n;
      grids++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fault_count == 0 && pending == 0) begin
      $display("PASS max_falling_path_sum_unit");
    end else begin
      $display("FAIL max_falling_path_sum_unit");
    end
    $finish;
  end

endmodule
